// ----- rtl/core/srgbxy_pkg.sv -----
package srgbxy_pkg;

  // field widths of the pixel and the chromaticity beat
  localparam int CHAN_W   = 8;
  localparam int CHROMA_W = 16;
  // quotient of the divider: one bit above the result so an overflow shows
  localparam int QUOT_W   = CHROMA_W + 1;

  localparam logic [CHROMA_W-1:0] BLACK_CODE = 16'd32768;
  localparam logic [QUOT_W-1:0]   CHROMA_MAX = 17'd65535;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } srgbxy_in_t;

  typedef struct packed {
    logic [CHROMA_W-1:0] x_chroma;
    logic [CHROMA_W-1:0] y_chroma;
  } srgbxy_out_t;

  // srgb d65 matrix, row major, scaled by 1e7
  localparam longint unsigned MAT_E7 [9] = '{
    64'd4124564, 64'd3575761, 64'd1804375,
    64'd2126729, 64'd7151522, 64'd721750,
    64'd193339,  64'd1191920, 64'd9503041
  };

  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  function automatic longint unsigned qmul30(input longint unsigned a,
                                             input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned pow5_q30(input longint unsigned r);
    longint unsigned r2;
    longint unsigned r4;
    r2 = qmul30(r, r);
    r4 = qmul30(r2, r2);
    return qmul30(r4, r);
  endfunction

  // linearized srgb code, frac fraction bits, evaluated at elaboration only
  function automatic longint unsigned lin_entry(input int unsigned c,
                                                input int unsigned frac);
    longint unsigned cc;
    longint unsigned t;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    cc = 64'(c);
    if (cc <= 64'd10) begin
      return (((cc * 64'd20) << frac) + 64'd32946) / 64'd65892;
    end
    t  = ((64'd1000 * cc + 64'd14025) << 30) / 64'd269025;
    lo = 64'd0;
    hi = Q30_ONE;
    // fifth root by bisection: largest r with r^5 <= t
    for (int k = 0; k < 32; k++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5_q30(mid) <= t) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    p = qmul30(qmul30(t, t), qmul30(lo, lo));
    return (p + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

  // matrix coefficient rounded to frac fraction bits
  function automatic longint unsigned mat_coef(input int unsigned i,
                                               input int unsigned frac);
    return ((MAT_E7[i] << frac) + 64'd5000000) / 64'd10000000;
  endfunction

endpackage

// ----- rtl/core/srgbxy_front.sv -----
module srgbxy_front
  import srgbxy_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  srgbxy_in_t               in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2*FRAC_BITS+1:0]   x_sum,
  output logic [2*FRAC_BITS+1:0]   y_sum,
  output logic [2*FRAC_BITS+3:0]   xyz_sum
);

  localparam int LIN_W  = FRAC_BITS + 1;
  localparam int COEF_W = FRAC_BITS;
  localparam int PROD_W = 2 * FRAC_BITS;
  localparam int XYZ_W  = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;
  localparam int NSTG   = 4;

  // constant tables
  logic [LIN_W-1:0]  lin_tab [256];
  logic [COEF_W-1:0] coef    [9];

  for (genvar c = 0; c < 256; c++) begin : g_lin
    assign lin_tab[c] = LIN_W'(lin_entry(c, FRAC_BITS));
  end

  for (genvar i = 0; i < 9; i++) begin : g_coef
    assign coef[i] = COEF_W'(mat_coef(i, FRAC_BITS));
  end

  // stage control
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] vin;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;

  assign vin = {v_r[NSTG-2:0], in_valid};
  assign rdy[3] = ~v_r[3] | out_ready;
  assign rdy[2] = ~v_r[2] | rdy[3];
  assign rdy[1] = ~v_r[1] | rdy[2];
  assign rdy[0] = ~v_r[0] | rdy[1];
  assign ld = rdy & vin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (v_r & ~rdy) | (vin & rdy);
    end
  end

  // payload
  logic [LIN_W-1:0]  lin_r  [3];
  logic [PROD_W-1:0] prod_r [9];
  logic [XYZ_W-1:0]  xyz_r  [3];
  logic [XYZ_W-1:0]  x_r;
  logic [XYZ_W-1:0]  y_r;
  logic [SUM_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      lin_r[0] <= lin_tab[in_data.red];
      lin_r[1] <= lin_tab[in_data.green];
      lin_r[2] <= lin_tab[in_data.blue];
    end
    if (ld[1]) begin
      for (int row = 0; row < 3; row++) begin
        for (int col = 0; col < 3; col++) begin
          prod_r[3*row+col] <= PROD_W'(lin_r[col]) * PROD_W'(coef[3*row+col]);
        end
      end
    end
    if (ld[2]) begin
      for (int row = 0; row < 3; row++) begin
        xyz_r[row] <= XYZ_W'(prod_r[3*row]) + XYZ_W'(prod_r[3*row+1])
                    + XYZ_W'(prod_r[3*row+2]);
      end
    end
    if (ld[3]) begin
      x_r   <= xyz_r[0];
      y_r   <= xyz_r[1];
      sum_r <= SUM_W'(xyz_r[0]) + SUM_W'(xyz_r[1]) + SUM_W'(xyz_r[2]);
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign x_sum     = x_r;
  assign y_sum     = y_r;
  assign xyz_sum   = sum_r;

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG-1] |-> (sum_r >= SUM_W'(x_r)) && (sum_r >= SUM_W'(y_r)))
    else $error("tristimulus sum below x or y");

endmodule

// ----- rtl/core/srgbxy_div.sv -----
module srgbxy_div
  import srgbxy_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2*FRAC_BITS+1:0]   num_x,
  input  logic [2*FRAC_BITS+1:0]   num_y,
  input  logic [2*FRAC_BITS+3:0]   den,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [QUOT_W-1:0]        quot_x,
  output logic [QUOT_W-1:0]        quot_y,
  output logic                     black
);

  localparam int SUM_W = 2 * FRAC_BITS + 4;
  localparam int DW    = SUM_W + 1;
  localparam int NW    = DW + QUOT_W;
  localparam logic [QUOT_W:0] PAIR_MAX = (QUOT_W+1)'(CHROMA_MAX) + 1'b1;

  // prep stage: dividend = num * 2 * 65535 + den, divisor = 2 * den
  logic            pv_r;
  logic            prdy;
  logic [NW-1:0]   pnx_r;
  logic [NW-1:0]   pny_r;
  logic [DW-1:0]   pd_r;
  logic            pblk_r;
  logic [NW-1:0]   pnx_nxt;
  logic [NW-1:0]   pny_nxt;

  // 2 * 65535 = 2^QUOT_W - 2
  assign pnx_nxt = (NW'(num_x) << QUOT_W) - (NW'(num_x) << 1) + NW'(den);
  assign pny_nxt = (NW'(num_y) << QUOT_W) - (NW'(num_y) << 1) + NW'(den);

  // one quotient bit per stage
  logic [QUOT_W-1:0] sv_r;
  logic [QUOT_W-1:0] srdy;
  logic [QUOT_W-1:0] blk_r;
  logic [DW-1:0]     rem_x_r [QUOT_W];
  logic [DW-1:0]     rem_y_r [QUOT_W];
  logic [DW-1:0]     dd_r    [QUOT_W];
  logic [QUOT_W-1:0] nq_x_r  [QUOT_W];
  logic [QUOT_W-1:0] nq_y_r  [QUOT_W];

  logic [QUOT_W-1:0] src_v;
  logic [QUOT_W-1:0] src_b;
  logic [DW-1:0]     src_rx  [QUOT_W];
  logic [DW-1:0]     src_ry  [QUOT_W];
  logic [DW-1:0]     src_d   [QUOT_W];
  logic [QUOT_W-1:0] src_qx  [QUOT_W];
  logic [QUOT_W-1:0] src_qy  [QUOT_W];
  logic [DW-1:0]     rem_x_nxt [QUOT_W];
  logic [DW-1:0]     rem_y_nxt [QUOT_W];
  logic [QUOT_W-1:0] nq_x_nxt  [QUOT_W];
  logic [QUOT_W-1:0] nq_y_nxt  [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    logic [DW:0]   tx;
    logic [DW:0]   ty;
    logic [DW-1:0] dfx;
    logic [DW-1:0] dfy;
    logic          gx;
    logic          gy;

    if (k == 0) begin : g_first
      assign src_rx[k] = pnx_r[NW-1:QUOT_W];
      assign src_ry[k] = pny_r[NW-1:QUOT_W];
      assign src_qx[k] = pnx_r[QUOT_W-1:0];
      assign src_qy[k] = pny_r[QUOT_W-1:0];
      assign src_d[k]  = pd_r;
      assign src_b[k]  = pblk_r;
      assign src_v[k]  = pv_r;
    end else begin : g_next
      assign src_rx[k] = rem_x_r[k-1];
      assign src_ry[k] = rem_y_r[k-1];
      assign src_qx[k] = nq_x_r[k-1];
      assign src_qy[k] = nq_y_r[k-1];
      assign src_d[k]  = dd_r[k-1];
      assign src_b[k]  = blk_r[k-1];
      assign src_v[k]  = sv_r[k-1];
    end

    if (k == QUOT_W - 1) begin : g_last
      assign srdy[k] = ~sv_r[k] | out_ready;
    end else begin : g_mid
      assign srdy[k] = ~sv_r[k] | srdy[k+1];
    end

    // shift in the next dividend bit, subtract when it fits
    // the difference is below the divisor whenever it is taken
    assign tx  = {src_rx[k], src_qx[k][QUOT_W-1]};
    assign ty  = {src_ry[k], src_qy[k][QUOT_W-1]};
    assign dfx = tx[DW-1:0] - src_d[k];
    assign dfy = ty[DW-1:0] - src_d[k];
    assign gx  = (tx >= {1'b0, src_d[k]});
    assign gy  = (ty >= {1'b0, src_d[k]});

    assign rem_x_nxt[k] = gx ? dfx : tx[DW-1:0];
    assign rem_y_nxt[k] = gy ? dfy : ty[DW-1:0];
    assign nq_x_nxt[k]  = {src_qx[k][QUOT_W-2:0], gx};
    assign nq_y_nxt[k]  = {src_qy[k][QUOT_W-2:0], gy};
  end

  assign prdy = ~pv_r | srdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      sv_r <= '0;
    end else begin
      if (prdy) begin
        pv_r <= in_valid;
      end
      sv_r <= (sv_r & ~srdy) | (src_v & srdy);
    end
  end

  always_ff @(posedge clk) begin
    if (prdy && in_valid) begin
      pnx_r  <= pnx_nxt;
      pny_r  <= pny_nxt;
      pd_r   <= {den, 1'b0};
      pblk_r <= (den == '0);
    end
    for (int k = 0; k < QUOT_W; k++) begin
      if (srdy[k] && src_v[k]) begin
        rem_x_r[k] <= rem_x_nxt[k];
        rem_y_r[k] <= rem_y_nxt[k];
        nq_x_r[k]  <= nq_x_nxt[k];
        nq_y_r[k]  <= nq_y_nxt[k];
        dd_r[k]    <= src_d[k];
        blk_r[k]   <= src_b[k];
      end
    end
  end

  assign in_ready  = prdy;
  assign out_valid = sv_r[QUOT_W-1];
  assign quot_x    = nq_x_r[QUOT_W-1];
  assign quot_y    = nq_y_r[QUOT_W-1];
  assign black     = blk_r[QUOT_W-1];

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !black |-> (quot_x <= CHROMA_MAX) && (quot_y <= CHROMA_MAX))
    else $error("chromaticity quotient above full scale");

  a_quot_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !black |-> ({1'b0, quot_x} + {1'b0, quot_y}) <= PAIR_MAX)
    else $error("x plus y exceeds one");

endmodule

// ----- rtl/core/srgb_to_cie_xy_16bit.sv -----
// srgb pixel to cie 1931 xy chromaticity. one 8-bit gamma-encoded pixel
// (red, green, blue) enters per beat and one beat leaves carrying x and y,
// each scaled to 0..65535 and rounded half up; pure black gives 32768 for
// both. the block is fully pipelined and takes a new pixel every clock
// while the output is not held back, so the sustained rate is one pixel
// per cycle. from input accept to output valid a beat passes the table
// lookup, matrix multiply and sums, a register that forms the dividend,
// the restoring divider (one quotient bit per stage, x and y side by side)
// and the output register. each stage holds its own valid bit and ready
// ripples back through empty stages, so bubbles collapse and in_ready
// stays high while a finished beat waits at the output, until all 23
// stages hold a beat. FRAC_BITS (12..24) sets the precision of the gamma
// table and the matrix coefficients; results follow the fixed-point
// arithmetic exactly.
module srgb_to_cie_xy_16bit
  import srgbxy_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  srgbxy_in_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output srgbxy_out_t out_data
);

  localparam int XYZ_W = 2 * FRAC_BITS + 2;
  localparam int SUM_W = 2 * FRAC_BITS + 4;

  // front end: linearize, matrix, tristimulus sum
  logic             f_valid;
  logic             f_ready;
  logic [XYZ_W-1:0] f_x;
  logic [XYZ_W-1:0] f_y;
  logic [SUM_W-1:0] f_sum;

  srgbxy_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .x_sum     (f_x),
    .y_sum     (f_y),
    .xyz_sum   (f_sum)
  );

  // x / sum and y / sum, rounded half up
  logic              d_valid;
  logic              d_ready;
  logic [QUOT_W-1:0] d_qx;
  logic [QUOT_W-1:0] d_qy;
  logic              d_black;

  srgbxy_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .num_x     (f_x),
    .num_y     (f_y),
    .den       (f_sum),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .quot_x    (d_qx),
    .quot_y    (d_qy),
    .black     (d_black)
  );

  // output register: black override and saturation
  logic        out_valid_r;
  srgbxy_out_t out_data_r;
  srgbxy_out_t out_data_nxt;

  assign d_ready = ~out_valid_r | out_ready;

  always_comb begin
    if (d_black) begin
      out_data_nxt.x_chroma = BLACK_CODE;
      out_data_nxt.y_chroma = BLACK_CODE;
    end else begin
      // x and y never exceed the sum, clamp kept as a guard
      out_data_nxt.x_chroma = (d_qx > CHROMA_MAX) ? CHROMA_MAX[CHROMA_W-1:0]
                                                  : d_qx[CHROMA_W-1:0];
      out_data_nxt.y_chroma = (d_qy > CHROMA_MAX) ? CHROMA_MAX[CHROMA_W-1:0]
                                                  : d_qy[CHROMA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (d_ready) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && d_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat valid right after reset");

endmodule

// ----- tb/srgb_to_cie_xy_16bit_tb.sv -----
`timescale 1ns / 100ps

module srgb_to_cie_xy_16bit_tb;
  import srgbxy_pkg::*;

  // precision of the gamma table and the matrix, same as the default of the block
  localparam int FRAC = 16;
  // generous cycle budget, far above the slowest correct run
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PIXELS = 1150;
  // receiver hold-off that fills the pipe and backs up the input
  localparam int LONG_HOLD = 200;
  localparam int LONG_HOLD_AT = 400;
  // drain cycles after the last expected beat, to catch stray beats
  localparam int TAIL_CYCLES = 40;

  // one pending pixel; wait_idle holds it back until every result is in
  typedef struct {
    srgbxy_in_t pix;
    bit         wait_idle;
  } pixel_job_t;

  // receiver patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_LIGHT_STALL,
    RX_EVERY_THIRD,
    RX_HEAVY_STALL
  } rx_mode_t;

  // d65 matrix, row major, scaled by 1e7
  localparam longint unsigned D65_E7 [9] = '{
    64'd4124564, 64'd3575761, 64'd1804375,
    64'd2126729, 64'd7151522, 64'd721750,
    64'd193339,  64'd1191920, 64'd9503041
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  srgbxy_in_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  srgbxy_out_t out_data;

  // gamma-expanded channel codes and matrix coefficients, both in FRAC fraction bits
  longint unsigned gamma_lut [256];
  longint unsigned xyz_coef [9];

  pixel_job_t  pixel_q[$];
  srgbxy_out_t chroma_expect_q[$];

  int unsigned pixels_sent = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  always #6 clk = ~clk;

  srgb_to_cie_xy_16bit #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // ---------------------------------------------------------------------------
  // chromaticity predictor
  // ---------------------------------------------------------------------------

  // q30 product, truncated
  function automatic longint unsigned q30_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned q30_fifth_power(input longint unsigned r);
    longint unsigned sq;
    longint unsigned quad;
    sq   = q30_mul(r, r);
    quad = q30_mul(sq, sq);
    return q30_mul(quad, r);
  endfunction

  // largest q30 value whose truncated fifth power stays at or below t
  function automatic longint unsigned q30_fifth_root(input longint unsigned t);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (q30_fifth_power(mid) <= t) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // srgb decode curve: linear segment up to code 10, power curve x^2.4 beyond,
  // with x^2.4 formed as t^2 * (t^(1/5))^2
  function automatic void build_gamma_lut();
    longint unsigned t;
    longint unsigned root;
    longint unsigned p;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        gamma_lut[c] = (((64'(c) * 64'd20) << FRAC) + 64'd32946) / 64'd65892;
      end else begin
        t    = ((64'd1000 * 64'(c) + 64'd14025) << 30) / 64'd269025;
        root = q30_fifth_root(t);
        p    = q30_mul(q30_mul(t, t), q30_mul(root, root));
        gamma_lut[c] = (p + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      end
    end
    for (int i = 0; i < 9; i++) begin
      xyz_coef[i] = ((D65_E7[i] << FRAC) + 64'd5000000) / 64'd10000000;
    end
  endfunction

  // num * 65535 / den rounded half up, split as 255 * 257 to keep it exact
  function automatic logic [CHROMA_W-1:0] ratio_to_chroma(input longint unsigned num,
                                                          input longint unsigned den);
    longint unsigned n255;
    longint unsigned q0;
    longint unsigned r0;
    longint unsigned q;
    n255 = num * 64'd255;
    q0   = n255 / den;
    r0   = n255 % den;
    q    = q0 * 64'd257 + (64'd2 * r0 * 64'd257 + den) / (64'd2 * den);
    if (q > 64'd65535) begin
      q = 64'd65535;
    end
    return q[CHROMA_W-1:0];
  endfunction

  function automatic srgbxy_out_t predict_chroma(input srgbxy_in_t px);
    longint unsigned lr;
    longint unsigned lg;
    longint unsigned lb;
    longint unsigned cx;
    longint unsigned cy;
    longint unsigned cz;
    longint unsigned total;
    srgbxy_out_t     res;
    lr = gamma_lut[px.red];
    lg = gamma_lut[px.green];
    lb = gamma_lut[px.blue];
    cx = lr * xyz_coef[0] + lg * xyz_coef[1] + lb * xyz_coef[2];
    cy = lr * xyz_coef[3] + lg * xyz_coef[4] + lb * xyz_coef[5];
    cz = lr * xyz_coef[6] + lg * xyz_coef[7] + lb * xyz_coef[8];
    total = cx + cy + cz;
    // only pure black sums to zero
    if (total == 64'd0) begin
      res.x_chroma = BLACK_CODE;
      res.y_chroma = BLACK_CODE;
    end else begin
      res.x_chroma = ratio_to_chroma(cx, total);
      res.y_chroma = ratio_to_chroma(cy, total);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_pixel(input int r, input int g, input int b,
                                      input bit wait_idle);
    pixel_job_t job;
    job.pix.red   = r[CHAN_W-1:0];
    job.pix.green = g[CHAN_W-1:0];
    job.pix.blue  = b[CHAN_W-1:0];
    job.wait_idle = wait_idle;
    pixel_q.push_back(job);
  endfunction

  // random pixel: half uniform, with weight on the dark end around the
  // linear segment, greys, single channels, saturated corners and near white
  function automatic void queue_random_pixel(input bit wait_idle);
    int kind;
    int g;
    kind = $urandom_range(0, 9);
    case (kind)
      5: begin
        queue_pixel($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 12),
                    wait_idle);
      end
      6: begin
        g = $urandom_range(0, 255);
        queue_pixel(g, g, g, wait_idle);
      end
      7: begin
        // one channel lit, others dark
        g = $urandom_range(0, 255);
        case ($urandom_range(0, 2))
          0: queue_pixel(g, 0, 0, wait_idle);
          1: queue_pixel(0, g, 0, wait_idle);
          default: queue_pixel(0, 0, g, wait_idle);
        endcase
      end
      8: begin
        queue_pixel($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                    $urandom_range(0, 1) * 255, wait_idle);
      end
      9: begin
        queue_pixel($urandom_range(240, 255), $urandom_range(240, 255),
                    $urandom_range(240, 255), wait_idle);
      end
      default: begin
        queue_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    wait_idle);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of beats with random gaps, fed from pixel_q
  // ---------------------------------------------------------------------------

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : driver
    pixel_job_t  job;
    logic        next_valid;
    srgbxy_in_t  next_data;
    next_valid = in_valid;
    next_data  = in_data;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      // record the expectation for a beat taken at this edge
      if (in_valid && in_ready) begin
        chroma_expect_q.push_back(predict_chroma(in_data));
        pixels_sent++;
        next_valid = 1'b0;
      end
      // a new beat may only go out once the current one is gone
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pixel_q.size() != 0 &&
                     !(pixel_q[0].wait_idle && chroma_expect_q.size() != 0)) begin
          job = pixel_q.pop_front();
          next_valid = 1'b1;
          next_data  = job.pix;
          if (burst_left <= 1) begin
            // end of burst: pick the next gap and burst length
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_valid <= next_valid;
    in_data  <= next_data;
  end

  // ---------------------------------------------------------------------------
  // receiver: pattern of its own, plus one long hold-off
  // ---------------------------------------------------------------------------

  rx_mode_t    rx_mode = RX_ALWAYS;
  int unsigned rx_phase_left = 0;
  int unsigned rx_tick = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk) begin : receiver
    logic next_ready;
    next_ready = 1'b0;
    if (rst_n) begin
      rx_tick++;
      if (!long_hold_done && pixels_sent >= LONG_HOLD_AT) begin
        // stop taking beats so the pipe fills and in_ready drops
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (rx_phase_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(50, 300);
      end else begin
        rx_phase_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
      end else begin
        case (rx_mode)
          RX_ALWAYS:      next_ready = 1'b1;
          RX_LIGHT_STALL: next_ready = ($urandom_range(0, 9) >= 3);
          RX_EVERY_THIRD: next_ready = (rx_tick % 3 == 0);
          default:        next_ready = ($urandom_range(0, 9) >= 7);
        endcase
      end
    end
    out_ready <= next_ready;
  end

  // ---------------------------------------------------------------------------
  // monitor: each result beat against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    srgbxy_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (chroma_expect_q.size() == 0) begin
        $error("unexpected beat: x_chroma %0d y_chroma %0d",
               out_data.x_chroma, out_data.y_chroma);
        fault_count++;
      end else begin
        want = chroma_expect_q.pop_front();
        if (out_data.x_chroma !== want.x_chroma) begin
          $error("x_chroma mismatch: expected %0d, actual %0d",
                 want.x_chroma, out_data.x_chroma);
          fault_count++;
        end
        if (out_data.y_chroma !== want.y_chroma) begin
          $error("y_chroma mismatch: expected %0d, actual %0d",
                 want.y_chroma, out_data.y_chroma);
          fault_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("srgb_to_cie_xy_16bit_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin
    build_gamma_lut();

    // directed: black, white, primaries and secondaries, the linear segment
    // edge (codes 10 and 11), lowest nonzero codes and alternating bit patterns
    queue_pixel(0, 0, 0, 1'b0);
    queue_pixel(255, 255, 255, 1'b0);
    queue_pixel(255, 0, 0, 1'b0);
    queue_pixel(0, 255, 0, 1'b0);
    queue_pixel(0, 0, 255, 1'b0);
    queue_pixel(255, 255, 0, 1'b0);
    queue_pixel(0, 255, 255, 1'b0);
    queue_pixel(255, 0, 255, 1'b0);
    queue_pixel(1, 0, 0, 1'b0);
    queue_pixel(0, 1, 0, 1'b0);
    queue_pixel(0, 0, 1, 1'b0);
    queue_pixel(1, 1, 1, 1'b0);
    queue_pixel(10, 10, 10, 1'b0);
    queue_pixel(11, 11, 11, 1'b0);
    queue_pixel(10, 0, 11, 1'b0);
    queue_pixel(254, 254, 254, 1'b0);
    queue_pixel(128, 128, 128, 1'b0);
    queue_pixel(8'h55, 8'haa, 8'h55, 1'b0);
    queue_pixel(8'haa, 8'h55, 8'haa, 1'b0);
    queue_pixel(255, 1, 0, 1'b0);
    queue_pixel(0, 0, 0, 1'b0);

    // random part; every so often the sender waits for the pipe to empty
    for (int k = 0; k < RANDOM_PIXELS; k++) begin
      queue_random_pixel(k % 250 == 0);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // all beats offered and taken
    while (pixel_q.size() != 0 || in_valid) @(posedge clk);
    // every expected result in, then let the pipe settle to catch stray beats
    while (chroma_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("srgb_to_cie_xy_16bit_tb: clean");
    end else begin
      $display("srgb_to_cie_xy_16bit_tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/srgbxy_pkg.sv
rtl/core/srgbxy_front.sv
rtl/core/srgbxy_div.sv
rtl/core/srgb_to_cie_xy_16bit.sv
tb/srgb_to_cie_xy_16bit_tb.sv
